/* design/assert_macros.svh */
// Assertion macros used by the checker file.
// Clocked assertion, masked while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BHC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define BHC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bhc_pkg.sv */
// ---------------------------------------------------------------------------
// bhc_pkg
// Types and constants of the bounded history cursor buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

	localparam int ENTRY_W = 32;
	localparam int CNT_W   = 5;

	// Limit register value after reset
	localparam logic [CNT_W-1:0] MAX_RESET = CNT_W'(16);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_NEXT  = 2'd1,
		OP_PREV  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [ENTRY_W-1:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry_out;
		logic               entry_valid;
		logic               has_next;
		logic               has_previous;
		logic [CNT_W-1:0]   cursor_out;
		logic [CNT_W-1:0]   count_out;
	} out_item_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;   // input transfer: latch item, start store read
		logic commit;    // update state and load the output register
	} ctl_cmd_t;

endpackage

`default_nettype wire

/* design/bhc_ctrl.sv */
// ---------------------------------------------------------------------------
// bhc_ctrl
// Sequencer: accepts an item, waits for the store read, commits it when
// the output register is free, and tracks the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module bhc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output bhc_pkg::ctl_cmd_t      cmd
);
	import bhc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output valid: set on commit, cleared on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* design/bhc_dpath.sv */
// ---------------------------------------------------------------------------
// bhc_dpath
// History state, entry ring memory, limit register and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bhc_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire bhc_pkg::ctl_cmd_t          cmd,
	input  wire bhc_pkg::in_item_t          in_data,
	input  wire logic                       cfg_we,
	input  wire logic [bhc_pkg::CNT_W-1:0]  cfg_data,
	output bhc_pkg::out_item_t              out_data
);
	import bhc_pkg::*;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
	localparam int LIM_CAP = (DEPTH < 31) ? DEPTH : 31;

	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] LIM_MAX  = CNT_W'(LIM_CAP);
	localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

	// Ring position of the pos-th oldest entry
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(pos);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[IDX_W-1:0];
	endfunction

	logic [ENTRY_W-1:0] store_q [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [CNT_W-1:0]   max_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   cursor_q;
	op_t                op_q;
	logic [ENTRY_W-1:0] value_q;
	out_item_t          out_q;

	logic [CNT_W-1:0]   fwd_cur;
	logic [CNT_W-1:0]   rd_pos;
	logic [IDX_W-1:0]   rd_addr;
	logic [CNT_W-1:0]   limit;
	logic               dup;
	logic               evict;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   oldest_d;
	logic [CNT_W-1:0]   count_d;
	logic [CNT_W-1:0]   cursor_d;
	logic [ENTRY_W-1:0] entry_d;
	logic               entry_valid_d;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	// Effective limit, clamped to at least one and at most the ring size or 31, whichever is smaller
	always_comb begin
		if (max_q == '0) begin
			limit = ONE;
		end else if (max_q > LIM_MAX) begin
			limit = LIM_MAX;
		end else begin
			limit = max_q;
		end
	end

	// Cursor after a forward step
	assign fwd_cur = (cursor_q < count_q) ? cursor_q + ONE : cursor_q;

	// Read position chosen from the incoming op
	always_comb begin
		rd_pos = '0;
		case (in_data.op)
			OP_ADD:  rd_pos = (count_q != '0) ? count_q - ONE : '0;
			OP_NEXT: rd_pos = (fwd_cur != '0) ? fwd_cur - ONE : '0;
			OP_PREV: rd_pos = (cursor_q > ONE) ? cursor_q - CNT_W'(2) : '0;
			OP_QUERY: rd_pos = '0;
			default: rd_pos = '0;
		endcase
	end

	assign rd_addr = slot_of(oldest_q, rd_pos);

	// Item latch and registered store read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_data.op;
			value_q   <= in_data.entry_value;
			rd_data_q <= store_q[rd_addr];
		end
	end

	// Update of the history for the latched item
	always_comb begin
		dup           = (count_q != '0) && (rd_data_q == value_q);
		evict         = (count_q >= limit);
		wr_en         = 1'b0;
		wr_addr       = slot_of(oldest_q, count_q);
		oldest_d      = oldest_q;
		count_d       = count_q;
		cursor_d      = cursor_q;
		entry_d       = '0;
		entry_valid_d = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (dup) begin
					cursor_d = count_q;
				end else begin
					wr_en = 1'b1;
					if (evict) begin
						oldest_d = (oldest_q == LAST_IDX) ? '0 : oldest_q + IDX_W'(1);
					end else begin
						count_d = count_q + ONE;
					end
					cursor_d = evict ? count_q : count_q + ONE;
				end
			end
			OP_NEXT: begin
				cursor_d = fwd_cur;
				if (fwd_cur != '0) begin
					entry_d       = rd_data_q;
					entry_valid_d = 1'b1;
				end
			end
			OP_PREV: begin
				if (cursor_q > ONE) begin
					cursor_d      = cursor_q - ONE;
					entry_d       = rd_data_q;
					entry_valid_d = 1'b1;
				end else if (count_q != '0) begin
					entry_d       = rd_data_q;
					entry_valid_d = 1'b1;
				end
			end
			OP_QUERY: begin
				cursor_d = cursor_q;
			end
			default: begin
				cursor_d = cursor_q;
			end
		endcase
	end

	// History state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			cursor_q <= '0;
		end else if (cmd.commit) begin
			oldest_q <= oldest_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
		end
	end

	// Ring memory write
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			store_q[wr_addr] <= value_q;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.entry_out    <= entry_d;
			out_q.entry_valid  <= entry_valid_d;
			out_q.has_next     <= (cursor_d < count_d);
			out_q.has_previous <= (cursor_d > ONE);
			out_q.cursor_out   <= cursor_d;
			out_q.count_out    <= count_d;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

/* design/bounded_history_cursor_buffer_top.sv */
// ---------------------------------------------------------------------------
// bounded_history_cursor_buffer_top
// Back/forward history of entry words in a ring with a one-based cursor.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries op and entry_value; output channel
//   out_valid/out_stall returns one result per item. A transfer happens on a
//   clock edge with valid high and stall low.
//   cfg_valid/cfg_ready writes the max_entries limit; cfg_ready is always high.
//   Write it only while no item is in flight.
// Sequencing:
//   The input transfer latches the item and registers the ring memory read;
//   the commit then updates the history and loads the output register. A new
//   item is taken only after the current one commits; in_stall is high meanwhile.
// Reset:
//   Count, cursor and oldest index clear, the limit returns to 16. The ring
//   memory is not cleared; entries are only used after being written.
// Stall:
//   A stalled result holds in the output register. One more item can be taken
//   and read meanwhile; it commits once the held result transfers.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_history_cursor_buffer_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire bhc_pkg::in_item_t          in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output bhc_pkg::out_item_t              out_data,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [bhc_pkg::CNT_W-1:0]  cfg_data
);
	import bhc_pkg::*;

	ctl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Sequencer
	bhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// History datapath
	bhc_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

/* design/bhc_checker.sv */
// ---------------------------------------------------------------------------
// bhc_checker
// Port-level checks of the history buffer results, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bhc_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire bhc_pkg::out_item_t  out_data
);
	import bhc_pkg::*;

	// No result shows while reset is held
	`BHC_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "out_valid during reset")

	// A stalled result stays and holds its payload
	`BHC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

	// Flags agree with cursor and count
	`BHC_ASSERT(a_has_next, out_valid |-> (out_data.has_next == (out_data.cursor_out < out_data.count_out)), "has_next mismatch")

	`BHC_ASSERT(a_has_prev, out_valid |-> (out_data.has_previous == (out_data.cursor_out > 5'd1)), "has_previous mismatch")

	// Cursor never passes the count; no entry word without entry_valid
	`BHC_ASSERT(a_cursor_rng, out_valid |-> (out_data.cursor_out <= out_data.count_out) && (out_data.entry_valid || (out_data.entry_out == '0)), "cursor or entry out of range")

endmodule

bind bounded_history_cursor_buffer_top bhc_checker u_bhc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
